@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the vertex numbering block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define PWVN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pwvn assertion failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define PWVN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pwvn assertion failed");

`endif

@@ rtl/core/pwvn_pkg.sv @@
// Package for the point weld vertex numbering block: widths, codes and types.
// Used by every module of the block; depends on nothing.
package pwvn_pkg;

    localparam int COORD_W    = 32;
    localparam int VID_W      = 10;
    localparam int DIM_W      = 2;
    localparam int TOL_W      = 32;
    localparam int DIST_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 96;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_SQ    = 1'd1;

    localparam logic [DIM_W-1:0] DIM_COUNT_RESET = 2'd3;

    // Coordinate select codes for the shared distance unit.
    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;

    // Bit positions inside m_tuser.
    localparam int USER_IS_NEW = 0;
    localparam int USER_FULL   = 1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [VID_W-1:0] id;
        coord_t           z;
        coord_t           y;
        coord_t           x;
    } entry_t;

    // Control of the shared distance unit for one cycle.
    typedef struct packed {
        logic load_diff;
        logic load_prod;
        logic acc_en;
        logic acc_first;
    } dctl_t;

endpackage

@@ rtl/core/pwvn_point_mem.sv @@
// Point store of the vertex numbering block: one write port, one registered read port.
// Depends on pwvn_pkg for the entry type.
module pwvn_point_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  pwvn_pkg::entry_t     wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output pwvn_pkg::entry_t     rdata
);
    import pwvn_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/pwvn_dist_unit.sv @@
// Shared squared-distance datapath: absolute difference, one 32x32 multiplier,
// and a saturating 64-bit accumulator. Depends on pwvn_pkg.
module pwvn_dist_unit (
    input  logic                          aclk,
    input  pwvn_pkg::dctl_t               ctl,
    input  pwvn_pkg::coord_t              op_a,
    input  pwvn_pkg::coord_t              op_b,
    output logic [pwvn_pkg::DIST_W-1:0]   acc_sum
);
    import pwvn_pkg::*;

    logic [COORD_W:0]   diff;
    logic [COORD_W:0]   diff_mag;
    logic [COORD_W-1:0] absdiff_reg;
    logic [DIST_W-1:0]  prod_reg;
    logic [DIST_W-1:0]  acc_reg;
    logic [DIST_W:0]    wide_sum;
    logic [DIST_W-1:0]  sat_sum;

    // The magnitude of a 33-bit difference of two 32-bit values fits in 32 bits.
    assign diff     = {op_a[COORD_W-1], op_a} - {op_b[COORD_W-1], op_b};
    assign diff_mag = diff[COORD_W] ? (~diff + (COORD_W+1)'(1)) : diff;

    assign wide_sum = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign sat_sum  = wide_sum[DIST_W] ? {DIST_W{1'b1}} : wide_sum[DIST_W-1:0];
    assign acc_sum  = ctl.acc_first ? prod_reg : sat_sum;

    always_ff @(posedge aclk) begin
        if (ctl.load_diff) begin
            absdiff_reg <= diff_mag[COORD_W-1:0];
        end
        if (ctl.load_prod) begin
            prod_reg <= DIST_W'(absdiff_reg) * DIST_W'(absdiff_reg);
        end
        if (ctl.acc_en) begin
            acc_reg <= acc_sum;
        end
    end

endmodule

@@ rtl/core/point_weld_vertex_numbering.sv @@
// Top level of the point weld vertex numbering block: sequencer, registers and ports.
// Depends on pwvn_pkg, pwvn_point_mem and pwvn_dist_unit.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_tvalid/s_tready   s_tdata: x, y, z; s_tuser: new_mesh
//   m_        out        m_tvalid/m_tready   m_tdata: vertex_id; m_tuser: is_new, store_full
//   cfg_      in         cfg_we              cfg_addr: register index; cfg_wdata: value
//
// An item is scanned against the stored points in arrival order, up to and including
// the first match. Each scanned point takes a memory read step and a difference step,
// then a multiply step and an accumulate step for each compared coordinate on the
// single multiplier.
// Reset is synchronous and active low; it clears the sequencer, the counters, the
// tolerance register and the output valid, and sets the dimension count to three. The
// point store is not cleared: only entries below the fill count are ever read. A stalled
// result holds in the output register while the next item is already accepted and
// scanned; the new result then waits in the finish step until the held one is taken.
module point_weld_vertex_numbering #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] x_coord, [63:32] y_coord, [95:64] z_coord
    input  logic [pwvn_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] new_mesh
    input  logic [pwvn_pkg::S_TUSER_W-1:0]     s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [9:0] vertex_id, [15:10] zero
    output logic [pwvn_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] is_new, [1] store_full
    output logic [pwvn_pkg::M_TUSER_W-1:0]     m_tuser,

    input  logic                               cfg_we,
    input  logic [pwvn_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pwvn_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pwvn_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ID_W  = (CNT_W > VID_W) ? CNT_W : VID_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SUB    = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_ACC    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [1:0]        k_reg, k_next;
    logic [1:0]        dims_last_reg, dims_last_next;
    logic              found_reg, found_next;
    logic [VID_W-1:0]  match_id_reg, match_id_next;
    logic [CNT_W-1:0]  point_count_reg, point_count_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [DIM_W-1:0]  dim_count_reg;
    logic [TOL_W-1:0]  tol_sq_reg;
    coord_t            px_reg, py_reg, pz_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [VID_W-1:0]  vid_reg, vid_next;
    logic              is_new_reg, is_new_next;
    logic              full_reg, full_next;

    logic              s_accept;
    logic              store_full_now;
    logic              last_idx;
    logic              last_coord;
    logic              is_match;
    logic [VID_W-1:0]  result_id;
    logic [1:0]        sel;
    coord_t            op_a, op_b;
    dctl_t             dctl;
    logic [DIST_W-1:0] acc_sum;
    logic              mem_we;
    entry_t            mem_wdata;
    entry_t            rd_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign store_full_now = (point_count_reg == MAX_CNT);
    assign last_idx       = ((CNT_W'(idx_reg) + CNT_W'(1)) == point_count_reg);
    assign last_coord     = (k_reg == dims_last_reg);
    assign is_match       = (acc_sum <= DIST_W'(tol_sq_reg));
    assign result_id      = found_reg ? match_id_reg : next_id_reg[VID_W-1:0];

    // Configuration writes take effect at once; they are meant to arrive only while
    // the block is idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_count_reg <= DIM_COUNT_RESET;
            tol_sq_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DIM_COUNT: dim_count_reg <= cfg_wdata[DIM_W-1:0];
                CFG_TOL_SQ:    tol_sq_reg    <= cfg_wdata[TOL_W-1:0];
            endcase
        end
    end

    // The point is captured on acceptance and held for the whole scan.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg <= s_tdata[COORD_W-1:0];
            py_reg <= s_tdata[2*COORD_W-1:COORD_W];
            pz_reg <= s_tdata[3*COORD_W-1:2*COORD_W];
        end
    end

    // The difference stage works on coordinate k in the SUB state of a stored point,
    // and on coordinate k+1 while the accumulator takes coordinate k.
    always_comb begin
        sel = (state_reg == ST_ACC) ? (k_reg + 2'd1) : k_reg;
        unique case (sel)
            COORD_X: begin
                op_a = px_reg;
                op_b = rd_entry.x;
            end
            COORD_Y: begin
                op_a = py_reg;
                op_b = rd_entry.y;
            end
            default: begin
                op_a = pz_reg;
                op_b = rd_entry.z;
            end
        endcase
    end

    assign mem_wdata.x  = px_reg;
    assign mem_wdata.y  = py_reg;
    assign mem_wdata.z  = pz_reg;
    assign mem_wdata.id = result_id;

    // Control of the shared distance unit, decoded from the sequencer state and the coordinate counter.
    always_comb begin
        dctl = '0;
        unique case (state_reg)
            ST_SUB: begin
                dctl.load_diff = 1'b1;
            end
            ST_MUL: begin
                dctl.load_prod = 1'b1;
            end
            ST_ACC: begin
                dctl.acc_en    = 1'b1;
                dctl.acc_first = (k_reg == '0);
                dctl.load_diff = !last_coord;
            end
            default: begin
            end
        endcase
    end

    // Sequencer: scan the store in arrival order, one coordinate at a time.
    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        dims_last_next   = dims_last_reg;
        found_next       = found_reg;
        match_id_next    = match_id_reg;
        point_count_next = point_count_reg;
        next_id_next     = next_id_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        vid_next         = vid_reg;
        is_new_next      = is_new_reg;
        full_next        = full_reg;
        mem_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    idx_next       = '0;
                    k_next         = '0;
                    found_next     = 1'b0;
                    // A dimension count of zero compares x alone, like a count of one.
                    dims_last_next = (dim_count_reg == '0) ? 2'd0 : (dim_count_reg - 2'd1);
                    if (s_tuser[0]) begin
                        point_count_next = '0;
                        next_id_next     = '0;
                    end
                    if (s_tuser[0] || (point_count_reg == '0)) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                k_next     = '0;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (!last_coord) begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_MUL;
                end else if (is_match) begin
                    found_next    = 1'b1;
                    match_id_next = rd_entry.id;
                    state_next    = ST_FINISH;
                end else if (last_idx) begin
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                // Wait here only while the previous result is still held.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (store_full_now) begin
                        vid_next    = found_reg ? match_id_reg : '0;
                        is_new_next = 1'b0;
                        full_next   = !found_reg;
                    end else begin
                        mem_we           = 1'b1;
                        vid_next         = result_id;
                        is_new_next      = !found_reg;
                        full_next        = 1'b0;
                        point_count_next = point_count_reg + CNT_W'(1);
                        if (!found_reg) begin
                            next_id_next = next_id_reg + ID_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            point_count_reg <= '0;
            next_id_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
            found_reg       <= 1'b0;
            k_reg           <= '0;
            idx_reg         <= '0;
            dims_last_reg   <= '0;
        end else begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            next_id_reg     <= next_id_next;
            m_tvalid_reg    <= m_tvalid_next;
            found_reg       <= found_next;
            k_reg           <= k_next;
            idx_reg         <= idx_next;
            dims_last_reg   <= dims_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        match_id_reg <= match_id_next;
        vid_reg      <= vid_next;
        is_new_reg   <= is_new_next;
        full_reg     <= full_next;
    end

    pwvn_point_mem #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (point_count_reg[IDX_W-1:0]),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    pwvn_dist_unit u_dist (
        .aclk    (aclk),
        .ctl     (dctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .acc_sum (acc_sum)
    );

    assign m_tvalid             = m_tvalid_reg;
    assign m_tdata              = {{(M_TDATA_W - VID_W){1'b0}}, vid_reg};
    assign m_tuser[USER_IS_NEW] = is_new_reg;
    assign m_tuser[USER_FULL]   = full_reg;

endmodule

@@ rtl/core/pwvn_checker.sv @@
// Port-level checker for the point weld vertex numbering block, bound to its top level.
// Depends on pwvn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwvn_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pwvn_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [pwvn_pkg::M_TUSER_W-1:0]   m_tuser
);
    import pwvn_pkg::*;

    // A result that is not taken keeps its valid and its contents.
    `PWVN_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A full-store result carries no number and no fresh flag.
    `PWVN_ASSERT_IMPL(a_full_blank, aclk, aresetn, m_tvalid && m_tuser[USER_FULL], (m_tdata == '0) && !m_tuser[USER_IS_NEW])

    // The block works on one point at a time: it is busy right after a transfer in.
    `PWVN_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // The bits above the vertex number stay zero.
    `PWVN_ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:VID_W] == '0)

endmodule

bind point_weld_vertex_numbering pwvn_checker u_pwvn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
